FILE: sv/tpws_pkg.sv
// shared widths, action codes, register indices and defaults for the time partition window scheduler
package tpws_pkg;

  localparam int NOW_W      = 64;
  localparam int FRAME_W    = 40;
  localparam int COUNT_W    = 5;
  localparam int SLOT_W     = 4;
  localparam int VM_W       = 4;
  localparam int VCPU_W     = 3;
  localparam int SPAN_W     = 32;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 1;

  localparam int MAX_WINDOWS_DEF = 16;

  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_HOLD    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_PICK    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT = 1'd1;

endpackage

FILE: sv/time_partition_window_scheduler.sv
// top level: command sequencer, frame state and shared 64-bit adder of the window scheduler
//
//  channel   ports                                      handshake
//  command   action now slot vm vcpu span               start high while busy low
//  result    ok in_window owner_vm owner_vcpu window     done high for one cycle
//            deadline
//  config    cfg_index cfg_data                         cfg_we high
//
//  load, hold, a refused pick and a refused restart answer straight from idle; a restart
//  opens a frame and sets its first switch time, and stops early when its frame end overflows
//  a pick inside the running frame walks straight on; one at a new frame opens it first and
//  one after whole frames have elapsed first catches up (64-step remainder unit); the walk
//  then steps past each finished window
//  rst is synchronous and clears frame state, hold flag and table valid bits
//  the receiver cannot stall: each result is shown once, on the done beat
module time_partition_window_scheduler #(
  parameter int MAX_WINDOWS = tpws_pkg::MAX_WINDOWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [tpws_pkg::ACTION_W-1:0]    action,
  input  logic [tpws_pkg::NOW_W-1:0]       now,
  input  logic [tpws_pkg::SLOT_W-1:0]      slot,
  input  logic [tpws_pkg::VM_W-1:0]        vm,
  input  logic [tpws_pkg::VCPU_W-1:0]      vcpu,
  input  logic [tpws_pkg::SPAN_W-1:0]      span,
  output logic                             done,
  output logic                             ok,
  output logic                             in_window,
  output logic [tpws_pkg::VM_W-1:0]        owner_vm,
  output logic [tpws_pkg::VCPU_W-1:0]      owner_vcpu,
  output logic [tpws_pkg::COUNT_W-1:0]     window,
  output logic [tpws_pkg::NOW_W-1:0]       deadline,
  input  logic                             cfg_we,
  input  logic [tpws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpws_pkg::FRAME_W-1:0]     cfg_data
);

  localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int NW = tpws_pkg::NOW_W;
  localparam int CW = tpws_pkg::COUNT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BEGIN = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_DIVW  = 4'd3;
  localparam logic [3:0] S_CATCH = 4'd4;
  localparam logic [3:0] S_LOAD0 = 4'd5;
  localparam logic [3:0] S_SET0  = 4'd6;
  localparam logic [3:0] S_WALK  = 4'd7;
  localparam logic [3:0] S_ADD   = 4'd8;
  localparam logic [3:0] S_OWN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]                         state;
  logic [tpws_pkg::ACTION_W-1:0]      act;
  logic [NW-1:0]                      now_q;
  logic                               held;
  logic [tpws_pkg::FRAME_W-1:0]       frame_length;
  logic [CW-1:0]                      window_count;
  logic [NW-1:0]                      frame_start;
  logic [NW-1:0]                      frame_end;
  logic [NW-1:0]                      switch_time;
  logic [CW-1:0]                      current_window;

  logic [CW-1:0]                      used;
  logic                               slot_ok;
  logic                               sched_ok;
  logic                               cw_in;

  logic                               tbl_we;
  logic [AW-1:0]                      tbl_raddr;
  logic [tpws_pkg::VM_W-1:0]          tbl_vm;
  logic [tpws_pkg::VCPU_W-1:0]        tbl_vcpu;
  logic [tpws_pkg::SPAN_W-1:0]        tbl_span;

  logic                               div_start;
  logic                               div_done;
  logic [tpws_pkg::FRAME_W-1:0]       div_rem;

  logic [NW-1:0]                      add_a;
  logic [NW-1:0]                      add_b;
  logic [NW:0]                        add_sum;
  logic [NW-1:0]                      pick_deadline;

  assign used     = (32'(window_count) > MAX_WINDOWS) ? CW'(MAX_WINDOWS) : window_count;
  assign slot_ok  = 32'(slot) < MAX_WINDOWS;
  assign sched_ok = (used != '0) && (frame_length != '0);
  assign cw_in    = current_window < used;
  assign busy     = state != S_IDLE;

  assign tbl_we    = start && !busy && (action == tpws_pkg::ACT_LOAD) && slot_ok;
  assign div_start = state == S_DIV;

  always_comb begin
    case (state)
      S_WALK:  tbl_raddr = AW'(current_window + 1'b1);
      S_OWN:   tbl_raddr = AW'(current_window);
      default: tbl_raddr = '0;
    endcase
  end

  // one adder serves frame end, first switch time and the window walk
  always_comb begin
    case (state)
      S_BEGIN: begin
        add_a = now_q;
        add_b = NW'(frame_length);
      end
      S_CATCH: begin
        add_a = frame_start;
        add_b = NW'(frame_length);
      end
      S_SET0: begin
        add_a = frame_start;
        add_b = NW'(tbl_span);
      end
      default: begin
        add_a = switch_time;
        add_b = NW'(tbl_span);
      end
    endcase
  end

  assign add_sum       = {1'b0, add_a} + {1'b0, add_b};
  assign pick_deadline = cw_in ? switch_time : frame_end;

  tpws_table #(
    .DEPTH (MAX_WINDOWS)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (tbl_we),
    .waddr (AW'(slot)),
    .wvm   (vm),
    .wvcpu (vcpu),
    .wspan (span),
    .raddr (tbl_raddr),
    .rvm   (tbl_vm),
    .rvcpu (tbl_vcpu),
    .rspan (tbl_span)
  );

  tpws_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (now_q - frame_end),
    .divisor   (frame_length),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      held           <= 1'b0;
      frame_length   <= '0;
      window_count   <= '0;
      frame_start    <= '0;
      frame_end      <= '0;
      switch_time    <= '0;
      current_window <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          tpws_pkg::REG_FRAME_LENGTH: frame_length <= cfg_data;
          tpws_pkg::REG_WINDOW_COUNT: window_count <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            act        <= action;
            now_q      <= now;
            ok         <= 1'b0;
            in_window  <= 1'b0;
            owner_vm   <= '0;
            owner_vcpu <= '0;
            window     <= '0;
            deadline   <= '0;
            case (action)
              tpws_pkg::ACT_LOAD: begin
                ok   <= slot_ok;
                done <= 1'b1;
              end
              tpws_pkg::ACT_RESTART: begin
                held <= 1'b0;
                if (sched_ok) begin
                  state <= S_BEGIN;
                end else begin
                  done <= 1'b1;
                end
              end
              tpws_pkg::ACT_HOLD: begin
                held <= 1'b1;
                done <= 1'b1;
              end
              default: begin
                if (held || !sched_ok) begin
                  done <= 1'b1;
                end else if (frame_end == '0 || now < frame_start) begin
                  state <= S_BEGIN;
                end else if (now >= frame_end) begin
                  state <= S_DIV;
                end else begin
                  state <= S_WALK;
                end
              end
            endcase
          end
        end
        S_BEGIN: begin
          if (add_sum[NW]) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            frame_start <= now_q;
            frame_end   <= add_sum[NW-1:0];
            state       <= S_LOAD0;
          end
        end
        S_DIV: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            frame_start <= now_q - NW'(div_rem);
            state       <= S_CATCH;
          end
        end
        S_CATCH: begin
          // frame start has moved even when the new end overflows
          if (add_sum[NW]) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            frame_end <= add_sum[NW-1:0];
            state     <= S_LOAD0;
          end
        end
        S_LOAD0: begin
          state <= S_SET0;
        end
        S_SET0: begin
          switch_time    <= add_sum[NW-1:0];
          current_window <= '0;
          if (act == tpws_pkg::ACT_RESTART) begin
            ok    <= 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (cw_in && now_q >= switch_time) begin
            current_window <= current_window + 1'b1;
            if ((current_window + 1'b1) < used) begin
              state <= S_ADD;
            end
          end else begin
            state <= S_OWN;
          end
        end
        S_ADD: begin
          switch_time <= add_sum[NW-1:0];
          state       <= S_WALK;
        end
        S_OWN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (pick_deadline > now_q) begin
            ok         <= 1'b1;
            in_window  <= cw_in;
            owner_vm   <= cw_in ? tbl_vm : '0;
            owner_vcpu <= cw_in ? tbl_vcpu : '0;
            window     <= cw_in ? current_window : used;
            deadline   <= pick_deadline;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result beat always lands with the sequencer back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while sequencer busy");

  // every accepted command either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command dropped");

  // a failed beat carries no in-window flag, window or deadline
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (!in_window && deadline == '0 && window == '0))
    else $error("failed result carries payload");

  // the walk never runs past the windows in use
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |-> (current_window < used))
    else $error("window walk past count");

  // the remainder unit is only started from a running pick
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (act == tpws_pkg::ACT_PICK && now_q >= frame_end))
    else $error("remainder unit started outside catch-up");

endmodule

FILE: sv/tpws_table.sv
// window table memory: span and owner per slot, valid bits stand in for the zero reset
module tpws_table #(
  parameter int DEPTH = tpws_pkg::MAX_WINDOWS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [tpws_pkg::VM_W-1:0]   wvm,
  input  logic [tpws_pkg::VCPU_W-1:0] wvcpu,
  input  logic [tpws_pkg::SPAN_W-1:0] wspan,
  input  logic [AW-1:0]               raddr,
  output logic [tpws_pkg::VM_W-1:0]   rvm,
  output logic [tpws_pkg::VCPU_W-1:0] rvcpu,
  output logic [tpws_pkg::SPAN_W-1:0] rspan
);

  localparam int ENTRY_W = tpws_pkg::VM_W + tpws_pkg::VCPU_W + tpws_pkg::SPAN_W;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid;
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wvm, wvcpu, wspan};
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      // addresses past the depth read as empty
      if (32'(raddr) < DEPTH) begin
        rd_valid <= valid[raddr];
      end else begin
        rd_valid <= 1'b0;
      end
    end
  end

  assign {rvm, rvcpu, rspan} = rd_valid ? rd_data : '0;

endmodule

FILE: sv/tpws_divider.sv
// bit-serial restoring remainder unit: 64-bit dividend, 40-bit divisor
module tpws_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tpws_pkg::NOW_W-1:0]   dividend,
  input  logic [tpws_pkg::FRAME_W-1:0] divisor,
  output logic                         done,
  output logic [tpws_pkg::FRAME_W-1:0] remainder
);

  localparam int CNT_W = $clog2(tpws_pkg::NOW_W + 1);

  logic [tpws_pkg::NOW_W-1:0]   quo;
  logic [tpws_pkg::FRAME_W-1:0] dsr;
  logic [CNT_W-1:0]             cnt;
  logic                         run;
  logic [tpws_pkg::FRAME_W:0]   trial;
  logic [tpws_pkg::FRAME_W:0]   diff;

  assign trial = {remainder, quo[tpws_pkg::NOW_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run       <= 1'b1;
        cnt       <= CNT_W'(tpws_pkg::NOW_W);
        quo       <= dividend;
        dsr       <= divisor;
        remainder <= '0;
      end else if (run) begin
        // remainder stays below the divisor, so one compare per bit
        if (trial >= {1'b0, dsr}) begin
          remainder <= diff[tpws_pkg::FRAME_W-1:0];
        end else begin
          remainder <= trial[tpws_pkg::FRAME_W-1:0];
        end
        quo <= {quo[tpws_pkg::NOW_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: tb/tb_time_partition_window_scheduler.sv
// self-checking testbench for the time partition window scheduler
`timescale 1ns / 1ps

module tb_time_partition_window_scheduler;
  import tpws_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BEATS = 1700;
  localparam logic [NOW_W-1:0] TICK_MAX = '1;
  localparam logic [NOW_W-1:0] FRAME_MAX = 64'h0000_00FF_FFFF_FFFF;

  typedef struct packed {
    logic               ok;
    logic               in_window;
    logic [VM_W-1:0]    owner_vm;
    logic [VCPU_W-1:0]  owner_vcpu;
    logic [COUNT_W-1:0] window;
    logic [NOW_W-1:0]   deadline;
  } sched_result_t;

  // window table, frame state and the queue of schedule answers still owed
  class sched_scoreboard;
    logic [NOW_W-1:0]   frame_len;
    logic [COUNT_W-1:0] win_count;
    logic [SPAN_W-1:0]  span_tab [MAX_WINDOWS_DEF];
    logic [VM_W-1:0]    vm_tab [MAX_WINDOWS_DEF];
    logic [VCPU_W-1:0]  vcpu_tab [MAX_WINDOWS_DEF];
    logic [NOW_W-1:0]   frame_start;
    logic [NOW_W-1:0]   frame_end;
    logic [NOW_W-1:0]   switch_at;
    int unsigned        cur_win;
    bit                 held;
    sched_result_t      due_results [$];
    int                 errors;
    int                 reg_writes;
    int                 in_window_picks;
    int                 tail_picks;
    int                 refused_picks;
    int                 per_action [4];

    function new();
      frame_len = '0;
      win_count = '0;
      foreach (span_tab[i]) begin
        span_tab[i] = '0;
        vm_tab[i] = '0;
        vcpu_tab[i] = '0;
      end
      frame_start = '0;
      frame_end = '0;
      switch_at = '0;
      cur_win = 0;
      held = 1'b0;
      errors = 0;
      reg_writes = 0;
      in_window_picks = 0;
      tail_picks = 0;
      refused_picks = 0;
      foreach (per_action[i]) per_action[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAME_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_FRAME_LENGTH: frame_len = {24'b0, data};
        REG_WINDOW_COUNT: win_count = data[COUNT_W-1:0];
      endcase
    endfunction

    // a count above the table size acts as the table size
    function int unsigned used_windows();
      return (win_count > MAX_WINDOWS_DEF) ? MAX_WINDOWS_DEF : int'(win_count);
    endfunction

    function bit open_frame(logic [NOW_W-1:0] t);
      if (used_windows() == 0 || frame_len == 0 || frame_len > (TICK_MAX - t)) return 1'b0;
      frame_start = t;
      frame_end = t + frame_len;
      cur_win = 0;
      switch_at = t + {32'b0, span_tab[0]};
      return 1'b1;
    endfunction

    // open a frame or catch up over whole frames, then walk past finished windows
    function bit locate(logic [NOW_W-1:0] t, output logic [NOW_W-1:0] dl);
      int unsigned n;
      int unsigned steps;
      bit valid;
      logic [NOW_W-1:0] rem;
      n = used_windows();
      steps = 0;
      valid = 1'b0;
      dl = '0;
      if (n == 0 || frame_len == 0) return 1'b0;
      if (frame_end == 0 || t < frame_start) begin
        valid = open_frame(t);
      end else if (t >= frame_end) begin
        rem = (t - frame_end) % frame_len;
        frame_start = t - rem;
        // on overflow the start has moved but the end stays
        if (frame_len <= TICK_MAX - frame_start) begin
          frame_end = frame_start + frame_len;
          cur_win = 0;
          switch_at = frame_start + {32'b0, span_tab[0]};
          valid = 1'b1;
        end
      end else begin
        valid = 1'b1;
      end
      while (valid && cur_win < n && t >= switch_at && steps < MAX_WINDOWS_DEF) begin
        cur_win++;
        steps++;
        if (cur_win < n) switch_at = switch_at + {32'b0, span_tab[cur_win]};
      end
      if (valid) begin
        dl = (cur_win < n) ? switch_at : frame_end;
        valid = dl > t;
      end
      return valid;
    endfunction

    function void note_beat(logic [ACTION_W-1:0] act, logic [NOW_W-1:0] t,
                            logic [SLOT_W-1:0] sl, logic [VM_W-1:0] v,
                            logic [VCPU_W-1:0] c, logic [SPAN_W-1:0] sp);
      sched_result_t r;
      logic [NOW_W-1:0] dl;
      int unsigned n;
      r = '0;
      per_action[act]++;
      case (act)
        ACT_LOAD: begin
          span_tab[sl] = sp;
          vm_tab[sl] = v;
          vcpu_tab[sl] = c;
          r.ok = 1'b1;
        end
        ACT_RESTART: begin
          held = 1'b0;
          r.ok = open_frame(t);
        end
        ACT_HOLD: held = 1'b1;
        ACT_PICK: begin
          if (!held && locate(t, dl)) begin
            n = used_windows();
            r.ok = 1'b1;
            r.deadline = dl;
            if (cur_win < n) begin
              r.in_window = 1'b1;
              r.owner_vm = vm_tab[cur_win];
              r.owner_vcpu = vcpu_tab[cur_win];
              r.window = COUNT_W'(cur_win);
              in_window_picks++;
            end else begin
              r.window = COUNT_W'(n);
              tail_picks++;
            end
          end else begin
            refused_picks++;
          end
        end
      endcase
      due_results.push_back(r);
    endfunction

    function void field_check(string name, logic [NOW_W-1:0] want, logic [NOW_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(sched_result_t got);
      sched_result_t want;
      if (due_results.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      want = due_results.pop_front();
      field_check("ok", 64'(want.ok), 64'(got.ok));
      field_check("in_window", 64'(want.in_window), 64'(got.in_window));
      field_check("owner_vm", 64'(want.owner_vm), 64'(got.owner_vm));
      field_check("owner_vcpu", 64'(want.owner_vcpu), 64'(got.owner_vcpu));
      field_check("window", 64'(want.window), 64'(got.window));
      field_check("deadline", want.deadline, got.deadline);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [ACTION_W-1:0]  action;
  logic [NOW_W-1:0]     now;
  logic [SLOT_W-1:0]    slot;
  logic [VM_W-1:0]      vm;
  logic [VCPU_W-1:0]    vcpu;
  logic [SPAN_W-1:0]    span;
  logic                 done;
  logic                 ok;
  logic                 in_window;
  logic [VM_W-1:0]      owner_vm;
  logic [VCPU_W-1:0]    owner_vcpu;
  logic [COUNT_W-1:0]   window;
  logic [NOW_W-1:0]     deadline;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FRAME_W-1:0]   cfg_data;

  sched_scoreboard sb;
  int cycles = 0;
  int beats_sent;
  int no_gap_run;

  time_partition_window_scheduler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .now(now), .slot(slot), .vm(vm), .vcpu(vcpu), .span(span),
    .done(done), .ok(ok), .in_window(in_window), .owner_vm(owner_vm),
    .owner_vcpu(owner_vcpu), .window(window), .deadline(deadline),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // register writes, accepted commands and result beats, all seen at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.set_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_beat(action, now, slot, vm, vcpu, span);
      if (done) sb.check_beat('{ok, in_window, owner_vm, owner_vcpu, window, deadline});
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [NOW_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // entered and left at a falling edge; start stays high into a back-to-back beat
  task automatic issue(logic [ACTION_W-1:0] act, logic [NOW_W-1:0] t,
                       logic [SLOT_W-1:0] sl = '0, logic [VM_W-1:0] v = '0,
                       logic [VCPU_W-1:0] c = '0, logic [SPAN_W-1:0] sp = '0);
    int gap;
    if (no_gap_run > 0) begin
      gap = 0;
      no_gap_run--;
    end else begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 19) == 0) no_gap_run = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    action <= act;
    now <= t;
    slot <= sl;
    vm <= v;
    vcpu <= c;
    span <= sp;
    do @(posedge clk); while (busy);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic pause_until_quiet();
    start <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAME_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(logic [NOW_W-1:0] fl, logic [COUNT_W-1:0] cnt);
    pause_until_quiet();
    write_reg(REG_FRAME_LENGTH, fl[FRAME_W-1:0]);
    write_reg(REG_WINDOW_COUNT, FRAME_W'(cnt));
  endtask

  task automatic run_directed();
    issue(ACT_PICK, '0);                           // nothing configured
    issue(ACT_RESTART, 64'd10);                    // zero count refuses
    program_regs(64'd100, 5'd4);
    issue(ACT_LOAD, '0, 4'd0, 4'd15, 3'd7, 32'd10);
    issue(ACT_LOAD, '0, 4'd1, 4'd0, 3'd0, 32'd0);
    issue(ACT_LOAD, '0, 4'd2, 4'd9, 3'd3, 32'd20);
    issue(ACT_LOAD, '0, 4'd3, 4'd6, 3'd5, 32'd30);
    issue(ACT_LOAD, TICK_MAX, 4'd15, 4'd15, 3'd7, '1);
    issue(ACT_RESTART, 64'd1000);
    issue(ACT_PICK, 64'd1005);
    issue(ACT_PICK, 64'd1010);                     // zero-length window skipped
    issue(ACT_PICK, 64'd1075);                     // idle tail
    issue(ACT_PICK, 64'd1715);                     // several frames elapsed
    issue(ACT_PICK, 64'd500);                      // before frame start
    issue(ACT_HOLD, '0);
    issue(ACT_PICK, 64'd600);
    issue(ACT_RESTART, 64'd2000);
    issue(ACT_PICK, TICK_MAX);                     // caught-up end overflows
    issue(ACT_RESTART, TICK_MAX - 64'd50);         // frame end would overflow
    program_regs(64'd50, 5'd31);                   // count above table size
    issue(ACT_LOAD, '0, 4'd0, 4'd0, 3'd0, '1);
    issue(ACT_RESTART, TICK_MAX - 64'd60);
    issue(ACT_PICK, TICK_MAX - 64'd55);            // switch times wrap
    program_regs(FRAME_MAX, 5'd8);
    issue(ACT_RESTART, '0);
    issue(ACT_PICK, 64'h1_0000_0005);
    program_regs(FRAME_MAX, 5'd2);                 // count shrinks under a running frame
    issue(ACT_PICK, 64'h1_0000_0006);
    program_regs('0, 5'd2);
    issue(ACT_PICK, 64'd7);
  endtask

  // one register setting, a table to match, then mostly picks that move through time
  task automatic run_random_phase();
    logic [SPAN_W-1:0] span_cap;
    logic [SPAN_W-1:0] spans [MAX_WINDOWS_DEF];
    logic [NOW_W-1:0]  span_sum;
    logic [NOW_W-1:0]  fl;
    logic [NOW_W-1:0]  t;
    logic [NOW_W-1:0]  reach;
    int unsigned       cnt;
    int unsigned       loads;
    int unsigned       r;
    case ($urandom_range(0, 5))
      0: span_cap = 32'd0;
      1: span_cap = 32'd3;
      2: span_cap = 32'd50;
      3: span_cap = 32'd1000;
      4: span_cap = 32'hF_FFFF;
      default: span_cap = '1;
    endcase
    r = $urandom_range(0, 19);
    if (r == 0) cnt = 0;
    else if (r == 1) cnt = $urandom_range(17, 31);
    else if (r == 2) cnt = MAX_WINDOWS_DEF;
    else cnt = $urandom_range(1, MAX_WINDOWS_DEF);
    loads = (cnt > MAX_WINDOWS_DEF) ? MAX_WINDOWS_DEF : cnt;
    span_sum = '0;
    for (int i = 0; i < MAX_WINDOWS_DEF; i++) begin
      spans[i] = $urandom_range(0, span_cap);
      if (i < loads) span_sum = span_sum + {32'b0, spans[i]};
    end
    r = $urandom_range(0, 9);
    if (r == 0) fl = '0;
    else if (r == 1) fl = FRAME_MAX;
    else if (r == 2) fl = rand64() & FRAME_MAX;
    else if (r < 7) fl = span_sum + rand64() % (span_sum / 2 + 64'd2);
    else fl = span_sum - rand64() % (span_sum / 2 + 64'd1);
    fl = fl & FRAME_MAX;
    r = $urandom_range(0, 9);
    if (r < 4) t = 64'($urandom_range(0, 1000));
    else if (r < 7) t = rand64() >> $urandom_range(1, 40);
    else if (r < 9) t = TICK_MAX - rand64() % (fl * 64'd6 + 64'd64);
    else t = rand64();
    program_regs(fl, COUNT_W'(cnt));
    for (int i = 0; i < loads; i++)
      issue(ACT_LOAD, rand64(), i[SLOT_W-1:0], VM_W'($urandom_range(0, 15)),
            VCPU_W'($urandom_range(0, 7)), spans[i]);
    issue(ACT_RESTART, t);
    reach = (fl == 0) ? 64'd200 : fl;
    repeat ($urandom_range(25, 70)) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: t = t + rand64() % (reach / 3 + 64'd1);
          5, 6: t = t + reach * 64'($urandom_range(1, 5)) + rand64() % reach;
          7: t = t + rand64() % 64'h100_0000_0000;
          8: t = t - rand64() % (reach + 64'd1);
          default: ;                               // same tick again
        endcase
        issue(ACT_PICK, t);
      end else if (r < 86) begin
        issue(ACT_RESTART, t);
      end else if (r < 89) begin
        issue(ACT_HOLD, rand64());
        repeat ($urandom_range(0, 2)) issue(ACT_PICK, t + 64'($urandom_range(0, 100)));
        issue(ACT_RESTART, t);
      end else if (r < 94) begin
        issue(ACT_LOAD, rand64(), SLOT_W'($urandom_range(0, 15)), VM_W'($urandom_range(0, 15)),
              VCPU_W'($urandom_range(0, 7)),
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, span_cap));
      end else if (r < 98) begin
        issue(ACTION_W'($urandom_range(0, 3)), rand64(), SLOT_W'($urandom_range(0, 15)),
              VM_W'($urandom_range(0, 15)), VCPU_W'($urandom_range(0, 7)), $urandom);
      end else begin
        pause_until_quiet();
        issue(ACT_PICK, t);
      end
    end
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    action = ACT_LOAD;
    now = '0;
    slot = '0;
    vm = '0;
    vcpu = '0;
    span = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_LENGTH;
    cfg_data = '0;
    beats_sent = 0;
    no_gap_run = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();
    begin : random_part
      int directed_beats;
      directed_beats = beats_sent;
      while (beats_sent < directed_beats + RANDOM_BEATS) run_random_phase();
    end
    pause_until_quiet();
    repeat (120) @(negedge clk);
    $display("run covered %0d commands: %0d loads, %0d restarts, %0d holds, %0d picks",
             beats_sent, sb.per_action[ACT_LOAD], sb.per_action[ACT_RESTART],
             sb.per_action[ACT_HOLD], sb.per_action[ACT_PICK]);
    $display("%0d reg writes; picks: %0d inside a window, %0d in the idle tail, %0d refused",
             sb.reg_writes, sb.in_window_picks, sb.tail_picks, sb.refused_picks);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
